@@ rtl/eta_pkg.sv @@
`default_nettype none

package eta_pkg;

	typedef enum logic [2:0] {
		OP_XY = 3'd0,
		OP_XZ = 3'd1,
		OP_YX = 3'd2,
		OP_YZ = 3'd3,
		OP_ZX = 3'd4,
		OP_ZY = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	localparam int OP_W   = 3;
	localparam int TRIG_W = 16;
	localparam int COEF_W = 17;
	localparam int MC_W   = 18;
	localparam int FRAC   = 15;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [MC_W-1:0]   mc_t;
	typedef coef_t [2:0][2:0]         mat_t;
	typedef mc_t [2:0][2:0]           mc_mat_t;

	localparam coef_t UNITY = 17'sd32768;

	// Elaboration-time ROM entry: round(32767 * sin(k * step))
	function automatic logic [14:0] sine_q15(input int k, input real step);
		return 15'($rtoi(32767.0 * $sin(step * k) + 0.5));
	endfunction

	function automatic mat_t ident_mat();
		mat_t m;
		m = '0;
		m[0][0] = UNITY;
		m[1][1] = UNITY;
		m[2][2] = UNITY;
		return m;
	endfunction

	// Right-handed basic rotation about one axis
	function automatic mat_t axis_mat(input axis_t axis, input trig_t s, input trig_t c);
		mat_t  m;
		axis_t p;
		axis_t q;
		coef_t cs;
		coef_t cc;
		m  = '0;
		cs = coef_t'(s);
		cc = coef_t'(c);
		case (axis)
			AXIS_X: begin
				p = AXIS_Y;
				q = AXIS_Z;
			end
			AXIS_Y: begin
				p = AXIS_Z;
				q = AXIS_X;
			end
			default: begin
				p = AXIS_X;
				q = AXIS_Y;
			end
		endcase
		m[axis][axis] = UNITY;
		m[p][p] = cc;
		m[q][q] = cc;
		m[p][q] = -cs;
		m[q][p] = cs;
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/eta_sincos.sv @@
`default_nettype none

module eta_sincos
	import eta_pkg::*;
#(
	parameter int ANGLE_BITS = 10
) (
	input  wire logic [ANGLE_BITS-1:0] angle,
	output trig_t                      sin_val,
	output trig_t                      cos_val
);

	localparam int QW    = 1 << (ANGLE_BITS - 2);
	localparam int IDX_W = ANGLE_BITS - 1;
	localparam logic [IDX_W-1:0]      QW_IDX = IDX_W'(QW);
	localparam logic [ANGLE_BITS-1:0] QW_ANG = ANGLE_BITS'(QW);
	localparam real ROM_STEP = 3.14159265358979323846 / (2.0 * QW);

	logic [14:0] rom [0:QW];

	for (genvar k = 0; k <= QW; k++) begin : g_rom
		assign rom[k] = sine_q15(k, ROM_STEP);
	end

	logic [ANGLE_BITS-1:0] cos_ang;

	assign cos_ang = angle + QW_ANG;

	function automatic trig_t lookup(input logic [ANGLE_BITS-1:0] a,
			input logic [14:0] tab [0:QW]);
		logic [1:0]       quad;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] addr;
		trig_t            v;
		quad = a[ANGLE_BITS-1 -: 2];
		idx  = {1'b0, a[ANGLE_BITS-3:0]};
		// mirror the quarter wave in odd quadrants, negate in the lower half
		addr = quad[0] ? (QW_IDX - idx) : idx;
		v    = trig_t'({1'b0, tab[addr]});
		return quad[1] ? -v : v;
	endfunction

	assign sin_val = lookup(angle, rom);
	assign cos_val = lookup(cos_ang, rom);

endmodule

`default_nettype wire

@@ rtl/eta_compose.sv @@
`default_nettype none

module eta_compose
	import eta_pkg::*;
(
	input  wire logic [OP_W-1:0] operation,
	input  wire trig_t           sin_first,
	input  wire trig_t           cos_first,
	input  wire trig_t           sin_second,
	input  wire trig_t           cos_second,
	output mc_mat_t              mc
);

	axis_t fa;
	axis_t fb;
	logic  ident;
	mat_t  ma;
	mat_t  mb;

	always_comb begin
		fa    = AXIS_X;
		fb    = AXIS_Y;
		ident = 1'b0;
		unique case (op_t'(operation))
			OP_XY: begin
				fa = AXIS_X;
				fb = AXIS_Y;
			end
			OP_XZ: begin
				fa = AXIS_X;
				fb = AXIS_Z;
			end
			OP_YX: begin
				fa = AXIS_Y;
				fb = AXIS_X;
			end
			OP_YZ: begin
				fa = AXIS_Y;
				fb = AXIS_Z;
			end
			OP_ZX: begin
				fa = AXIS_Z;
				fb = AXIS_X;
			end
			OP_ZY: begin
				fa = AXIS_Z;
				fb = AXIS_Y;
			end
			// unused codes: identity passes the vector through
			default: ident = 1'b1;
		endcase
	end

	assign ma = ident ? ident_mat() : axis_mat(fa, sin_first, cos_first);
	assign mb = ident ? ident_mat() : axis_mat(fb, sin_second, cos_second);

	// Two distinct axes leave at most one nonzero term per entry
	always_comb begin
		logic signed [2*COEF_W+1:0] acc;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = '0;
				for (int k = 0; k < 3; k++) begin
					acc = acc + mb[i][k] * ma[k][j];
				end
				mc[i][j] = mc_t'(acc >>> FRAC);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/euler_two_axis_rotator.sv @@
`default_nettype none

// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   operation, angle_first, angle_second, in_x/y/z
// out      output     out_valid/out_stall out_x, out_y, out_z
//
// Four register stages: trig lookup, matrix compose, coordinate products,
// sum/shift/saturate into the output register. One vector per cycle while not held.
// The pipeline advances as a whole; it holds only while the output register is
// full and stalled, and in_stall follows that condition.
// arst_n clears the valid bits; data registers are not reset.

module euler_two_axis_rotator
	import eta_pkg::*;
#(
	parameter int ANGLE_BITS = 10,
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [OP_W-1:0]              operation,
	input  wire logic [ANGLE_BITS-1:0]        angle_first,
	input  wire logic [ANGLE_BITS-1:0]        angle_second,
	input  wire logic signed [COORD_BITS-1:0] in_x,
	input  wire logic signed [COORD_BITS-1:0] in_y,
	input  wire logic signed [COORD_BITS-1:0] in_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS-1:0]      out_x,
	output logic signed [COORD_BITS-1:0]      out_y,
	output logic signed [COORD_BITS-1:0]      out_z
);

	localparam int PW = COORD_BITS + MC_W;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] MAXV = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

	logic adv;

	logic                         vld_s1;
	logic [OP_W-1:0]              op_s1;
	trig_t                        sa_s1, ca_s1, sb_s1, cb_s1;
	logic signed [COORD_BITS-1:0] v_s1 [3];

	logic                         vld_s2;
	mc_mat_t                      mc_s2;
	logic signed [COORD_BITS-1:0] v_s2 [3];

	logic                         vld_s3;
	logic signed [PW-1:0]         prod_s3 [3][3];

	logic                         vld_s4;
	logic signed [COORD_BITS-1:0] res_s4 [3];

	trig_t   sa, ca, sb, cb;
	mc_mat_t mc;

	// Advance whenever the output register is empty or being taken
	assign adv      = !(vld_s4 && out_stall);
	assign in_stall = !adv;

	eta_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_first (
		.angle   (angle_first),
		.sin_val (sa),
		.cos_val (ca)
	);

	eta_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_second (
		.angle   (angle_second),
		.sin_val (sb),
		.cos_val (cb)
	);

	eta_compose u_compose (
		.operation  (op_s1),
		.sin_first  (sa_s1),
		.cos_first  (ca_s1),
		.sin_second (sb_s1),
		.cos_second (cb_s1),
		.mc         (mc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= operation;
			sa_s1   <= sa;
			ca_s1   <= ca;
			sb_s1   <= sb;
			cb_s1   <= cb;
			v_s1[0] <= in_x;
			v_s1[1] <= in_y;
			v_s1[2] <= in_z;

			mc_s2 <= mc;
			v_s2  <= v_s1;

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s3[i][j] <= mc_s2[i][j] * v_s2[j];
				end
			end
		end
	end

	// Sum, shift and saturate each row
	always_ff @(posedge clk) begin
		logic signed [SW-1:0] acc;
		logic signed [SW-1:0] sh;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				acc = SW'(prod_s3[i][0]) + SW'(prod_s3[i][1]) + SW'(prod_s3[i][2]);
				sh  = acc >>> FRAC;
				if (sh > MAXV) begin
					res_s4[i] <= MAXV[COORD_BITS-1:0];
				end else if (sh < MINV) begin
					res_s4[i] <= MINV[COORD_BITS-1:0];
				end else begin
					res_s4[i] <= sh[COORD_BITS-1:0];
				end
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_x     = res_s4[0];
	assign out_y     = res_s4[1];
	assign out_z     = res_s4[2];

endmodule

`default_nettype wire

@@ dv/euler_two_axis_rotator_test.sv @@
module euler_two_axis_rotator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import eta_pkg::*;

	localparam int ANGLE_BITS = 10;
	localparam int COORD_BITS = 32;
	localparam int QW = 1 << (ANGLE_BITS - 2);
	localparam int ANGLE_MASK = (1 << ANGLE_BITS) - 1;
	localparam longint ONE_Q15 = 32768;
	localparam real PI_HALF = 3.14159265358979323846 / 2.0;
	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] Q_ONE = 1 << 16;

	typedef longint mat3_t [3][3];

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} vec_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [OP_W-1:0]              operation = '0;
	logic [ANGLE_BITS-1:0]        angle_first = '0;
	logic [ANGLE_BITS-1:0]        angle_second = '0;
	logic signed [COORD_BITS-1:0] in_x = '0;
	logic signed [COORD_BITS-1:0] in_y = '0;
	logic signed [COORD_BITS-1:0] in_z = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;

	int   quarter_sine [0:QW];
	vec_t expected_vectors [$];
	bit   steady_run = 1'b0;
	int   fail_count = 0;
	int   sent_count = 0;
	int   checked_count = 0;
	int   limit_count = 0;

	euler_two_axis_rotator #(
		.ANGLE_BITS(ANGLE_BITS),
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.angle_first(angle_first),
		.angle_second(angle_second),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint trig_sin(input int a);
		int     quad;
		int     idx;
		longint v;
		quad = (a >> (ANGLE_BITS - 2)) & 3;
		idx  = a & (QW - 1);
		v    = (quad & 1) ? quarter_sine[QW - idx] : quarter_sine[idx];
		return (quad & 2) ? -v : v;
	endfunction

	function automatic void axis_rotation(input axis_t ax, input int ang, output mat3_t m);
		longint s;
		longint c;
		int     a;
		int     p;
		int     q;
		s = trig_sin(ang & ANGLE_MASK);
		c = trig_sin((ang + QW) & ANGLE_MASK);
		a = int'(ax);
		p = (a + 1) % 3;
		q = (a + 2) % 3;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = 0;
		m[a][a] = ONE_Q15;
		m[p][p] = c;
		m[q][q] = c;
		m[p][q] = -s;
		m[q][p] = s;
	endfunction

	function automatic vec_t predict_rotation(
		input logic [OP_W-1:0]              op,
		input logic [ANGLE_BITS-1:0]        a1,
		input logic [ANGLE_BITS-1:0]        a2,
		input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y,
		input logic signed [COORD_BITS-1:0] z
	);
		mat3_t  ma;
		mat3_t  mb;
		mat3_t  mc;
		longint v [3];
		longint o [3];
		longint acc;
		longint maxv;
		longint minv;
		axis_t  ax1;
		axis_t  ax2;
		vec_t   res;
		res = '{x: x, y: y, z: z};
		case (op)
			OP_XY: begin ax1 = AXIS_X; ax2 = AXIS_Y; end
			OP_XZ: begin ax1 = AXIS_X; ax2 = AXIS_Z; end
			OP_YX: begin ax1 = AXIS_Y; ax2 = AXIS_X; end
			OP_YZ: begin ax1 = AXIS_Y; ax2 = AXIS_Z; end
			OP_ZX: begin ax1 = AXIS_Z; ax2 = AXIS_X; end
			OP_ZY: begin ax1 = AXIS_Z; ax2 = AXIS_Y; end
			// unused codes pass the vector through
			default: return res;
		endcase
		v[0] = x;
		v[1] = y;
		v[2] = z;
		maxv = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		minv = -maxv - 1;
		axis_rotation(ax1, int'(a1), ma);
		axis_rotation(ax2, int'(a2), mb);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += mb[i][k] * ma[k][j];
				mc[i][j] = acc >>> FRAC;
			end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += mc[i][j] * v[j];
			acc = acc >>> FRAC;
			if (acc > maxv)
				acc = maxv;
			if (acc < minv)
				acc = minv;
			o[i] = acc;
		end
		res.x = o[0][COORD_BITS-1:0];
		res.y = o[1][COORD_BITS-1:0];
		res.z = o[2][COORD_BITS-1:0];
		return res;
	endfunction

	task automatic send_request(
		input logic [OP_W-1:0]              op,
		input logic [ANGLE_BITS-1:0]        a1,
		input logic [ANGLE_BITS-1:0]        a2,
		input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y,
		input logic signed [COORD_BITS-1:0] z
	);
		@(negedge clk);
		while (!steady_run && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation    <= op;
		angle_first  <= a1;
		angle_second <= a2;
		in_x         <= x;
		in_y         <= y;
		in_z         <= z;
		in_valid     <= 1'b1;
		// hold the request until the block takes it
		do @(posedge clk); while (in_stall);
		expected_vectors.push_back(predict_rotation(op, a1, a2, x, y, z));
		sent_count++;
	endtask

	function automatic logic [OP_W-1:0] rand_operation();
		if ($urandom_range(0, 19) == 0)
			return OP_W'($urandom_range(6, 7));
		return OP_W'($urandom_range(0, 5));
	endfunction

	function automatic logic [ANGLE_BITS-1:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ANGLE_BITS'(ANGLE_MASK);
			2: return ANGLE_BITS'($urandom_range(0, 3) * QW);
			default: return ANGLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord(input int wide_pct);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < wide_pct) begin
			if ($urandom_range(0, 1))
				return CMAX - COORD_BITS'($urandom_range(0, 65535));
			return CMIN + COORD_BITS'($urandom_range(0, 65535));
		end
		if (pick < wide_pct + 30)
			return COORD_BITS'($urandom_range(0, 20 << 16)) - COORD_BITS'(10 << 16);
		return COORD_BITS'($urandom);
	endfunction

	task automatic run_random(input int count, input int wide_pct);
		logic [ANGLE_BITS-1:0] a2;
		for (int n = 0; n < count; n++) begin
			a2 = ($urandom_range(0, 9) == 0) ? '0 : rand_angle();
			send_request(rand_operation(), rand_angle(), a2,
				rand_coord(wide_pct), rand_coord(wide_pct), rand_coord(wide_pct));
		end
	endtask

	task automatic test_directed_cases();
		// every code with zero angles: identity, and pass-through for unused codes
		for (int op = 0; op < 8; op++)
			send_request(OP_W'(op), '0, '0, Q_ONE, -2 * Q_ONE, 7 * Q_ONE / 2);
		send_request(OP_XY, 10'd256, 10'd0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
		send_request(OP_XZ, 10'd0, 10'd512, Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
		send_request(OP_YX, 10'd768, 10'd256, -Q_ONE, 5 * Q_ONE, -3 * Q_ONE);
		send_request(OP_YZ, 10'd1023, 10'd1023, 4 * Q_ONE, -Q_ONE, 9 * Q_ONE);
		send_request(OP_ZX, 10'd128, 10'd0, 3 * Q_ONE, Q_ONE, -6 * Q_ONE);
		send_request(OP_ZY, 10'd512, 10'd768, -8 * Q_ONE, 2 * Q_ONE, Q_ONE);
		send_request(OP_ZY, 10'd1, 10'd1, 1, -1, 0);
		// full-scale coordinates, unity coefficients
		send_request(OP_XY, '0, '0, CMAX, CMAX, CMAX);
		send_request(OP_YZ, '0, '0, CMIN, CMIN, CMIN);
		// 45 degrees on both axes drives the sums past the range
		send_request(OP_XY, 10'd128, 10'd128, CMAX, CMAX, CMAX);
		send_request(OP_XZ, 10'd128, 10'd128, CMIN, CMIN, CMIN);
		send_request(OP_ZX, 10'd128, 10'd896, CMAX, CMIN, CMAX);
		send_request(OP_YX, 10'd384, 10'd640, CMIN, CMAX, CMIN);
		send_request(OP_W'(6), 10'd1023, 10'd1023, CMAX, CMIN, '0);
		send_request(OP_W'(7), 10'd300, 10'd700, CMIN, CMAX, -1);
	endtask

	task automatic test_random_angles();
		run_random(450, 10);
	endtask

	task automatic test_steady_stream();
		steady_run = 1'b1;
		run_random(250, 10);
		steady_run = 1'b0;
	endtask

	task automatic test_saturation_heavy();
		run_random(230, 70);
	endtask

	always @(negedge clk)
		out_stall <= !steady_run && ($urandom_range(0, 99) < 13);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vectors.size() == 0) begin
				$error("result with no request outstanding: %0d %0d %0d", out_x, out_y, out_z);
				fail_count++;
			end else begin
				vec_t want;
				want = expected_vectors.pop_front();
				checked_count++;
				if (out_x !== want.x) begin
					$error("out_x expected %0d actual %0d", want.x, out_x);
					fail_count++;
				end
				if (out_y !== want.y) begin
					$error("out_y expected %0d actual %0d", want.y, out_y);
					fail_count++;
				end
				if (out_z !== want.z) begin
					$error("out_z expected %0d actual %0d", want.z, out_z);
					fail_count++;
				end
				if (want.x == CMAX || want.x == CMIN || want.y == CMAX || want.y == CMIN
						|| want.z == CMAX || want.z == CMIN)
					limit_count++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("euler_two_axis_rotator_test NOT OK");
		$finish;
	end

	initial begin
		for (int k = 0; k <= QW; k++)
			quarter_sine[k] = $rtoi(32767.0 * $sin(PI_HALF * k / QW) + 0.5);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_angles();
		test_steady_stream();
		test_saturation_heavy();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_vectors.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d rotation requests over all axis orders and unused codes, %0d results checked",
			sent_count, checked_count);
		$display("%0d results hit the saturation limits", limit_count);
		if (fail_count == 0)
			$display("euler_two_axis_rotator_test OK");
		else
			$display("euler_two_axis_rotator_test NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/eta_pkg.sv
rtl/eta_sincos.sv
rtl/eta_compose.sv
rtl/euler_two_axis_rotator.sv
dv/euler_two_axis_rotator_test.sv
